// ----- design/assert_macros.svh -----
// assertion macros used by the scheduler top level
// no dependencies; included by the scheduler top level, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define RRCQS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define RRCQS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/rrcqs_pkg.sv -----
// shared constants and types of the round-robin class queue scheduler
// no dependencies; imported by the channel interfaces, the top level and the testbench
package rrcqs_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 1024;

   localparam int CLASS_W = 3;
   localparam int INDEX_W = 32;
   localparam int POS_W   = 10;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENQ,
      ST_DEQ_META,
      ST_DEQ_DATA
   } state_type;

endpackage

// ----- design/rrcqs_channels.sv -----
// valid/ready channels of the scheduler: request beats and response beats
// depends on rrcqs_pkg for the field widths
interface rrcqs_req_if import rrcqs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [CLASS_W-1:0] class_id;
   logic [INDEX_W-1:0] buffer_index;

   modport source (output valid, op, class_id, buffer_index, input ready);
   modport sink   (input valid, op, class_id, buffer_index, output ready);
endinterface

interface rrcqs_rsp_if import rrcqs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [INDEX_W-1:0] out_index;
   logic [CLASS_W-1:0] out_class;
   logic [POS_W-1:0]   queue_position;
   logic [POS_W-1:0]   remaining;

   modport source (output valid, ok, out_index, out_class, queue_position, remaining,
                   input ready);
   modport sink   (input valid, ok, out_index, out_class, queue_position, remaining,
                   output ready);
endinterface

// ----- design/rrcqs_ram.sv -----
// generic single-clock ram: one write port, one read port, registered read data
// no dependencies
module rrcqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/round_robin_class_queue_scheduler.sv -----
// Round-robin class queue scheduler: one packet index fifo per traffic class.
// Request channel (req_bus): op selects enqueue (class_id, buffer_index) or
// dequeue. Response channel (rsp_bus): one beat per request with ok, out_index,
// out_class, queue_position and remaining.
// One request is worked on at a time. An enqueue passes through ST_ENQ after accept
// (head/count ram read, then fifo write); a dequeue through ST_DEQ_META and ST_DEQ_DATA
// (head/count ram read, then fifo ram read, then response); a dequeue that finds every
// queue empty answers from ST_DEQ_META. The next request is accepted in the cycle after
// the response is loaded, so no new request is taken before the last one is answered;
// the pace is set by the registered read data of the two rams.
// Dequeue picks the first non-empty class after the last served one, with wrap.
// Reset (synchronous) empties every queue and makes class 0 first to be served;
// no clearing pass is needed since head/count entries carry valid bits.
// The response sits in an output register; when the receiver stalls, the
// work in flight waits at its last step and no new request is taken.
module round_robin_class_queue_scheduler
   import rrcqs_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   rrcqs_req_if.sink   req_bus,
   rrcqs_rsp_if.source rsp_bus
);

`include "assert_macros.svh"

   localparam int CLW = $clog2(NUM_CLASSES);
   localparam int CPW = CLW + 1;
   localparam int HW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SW  = CW + 1;
   localparam int MW  = HW + CW;
   localparam int SD  = NUM_CLASSES * QUEUE_DEPTH;
   localparam int SAW = $clog2(SD);

   state_type state_ff, state_in;

   logic [CLW-1:0]     cls_ff, cls_in;
   logic [CLASS_W-1:0] enq_class_ff, enq_class_in;
   logic               cls_ok_ff, cls_ok_in;
   logic               deq_empty_ff, deq_empty_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [CW-1:0]      rem_ff, rem_in;

   logic [NUM_CLASSES-1:0] meta_valid_ff, meta_valid_in;
   logic [NUM_CLASSES-1:0] nonempty_ff, nonempty_in;
   logic [CLW-1:0]         last_served_ff, last_served_in;
   logic                   meta_hit_ff, meta_hit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [CLASS_W-1:0] rsp_class_ff, rsp_class_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]   rsp_rem_ff, rsp_rem_in;

   logic           req_fire;
   logic           out_free;
   logic           rsp_load;
   logic [CLW-1:0] sel_cls;
   logic           sel_any;

   logic           meta_re, meta_we;
   logic [CLW-1:0] meta_raddr;
   logic [MW-1:0]  meta_wdata, meta_rdata;
   logic [HW-1:0]  meta_head;
   logic [CW-1:0]  meta_count;

   logic               store_we, store_re;
   logic [SAW-1:0]     store_waddr, store_raddr;
   logic [INDEX_W-1:0] store_rdata;

   logic [SW-1:0] slot_sum, head_inc;
   logic [HW-1:0] slot, head_next;
   logic [CW-1:0] count_dec;
   logic          queue_full;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // rotating priority encoder over the non-empty bitmap
   always_comb begin
      logic [CPW-1:0] cand;
      sel_cls = '0;
      sel_any = 1'b0;
      for (int k = NUM_CLASSES; k >= 1; k--) begin
         cand = CPW'(last_served_ff) + CPW'(k);
         if (cand >= CPW'(NUM_CLASSES)) begin
            cand = cand - CPW'(NUM_CLASSES);
         end
         if (nonempty_ff[cand[CLW-1:0]]) begin
            sel_cls = cand[CLW-1:0];
            sel_any = 1'b1;
         end
      end
   end

   // head/count of a class never written read as zero
   assign {meta_head, meta_count} = meta_hit_ff ? meta_rdata : '0;

   assign queue_full = (meta_count >= CW'(QUEUE_DEPTH));
   assign slot_sum   = SW'(meta_head) + SW'(meta_count);
   assign slot       = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                                      : HW'(slot_sum);
   assign head_inc   = SW'(meta_head) + SW'(1);
   assign head_next  = (head_inc == SW'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
   assign count_dec  = meta_count - CW'(1);

   assign store_waddr = SAW'(cls_ff) * SAW'(QUEUE_DEPTH) + SAW'(slot);
   assign store_raddr = SAW'(cls_ff) * SAW'(QUEUE_DEPTH) + SAW'(meta_head);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_bus.op == OP_DEQUEUE) ? ST_DEQ_META : ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEQ_META: begin
            if (!deq_empty_ff) begin
               state_in = ST_DEQ_DATA;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEQ_DATA: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls and register updates
   always_comb begin
      cls_in         = cls_ff;
      enq_class_in   = enq_class_ff;
      cls_ok_in      = cls_ok_ff;
      deq_empty_in   = deq_empty_ff;
      idx_in         = idx_ff;
      rem_in         = rem_ff;
      meta_valid_in  = meta_valid_ff;
      nonempty_in    = nonempty_ff;
      last_served_in = last_served_ff;
      meta_hit_in    = meta_hit_ff;

      rsp_load     = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_index_in = rsp_index_ff;
      rsp_class_in = rsp_class_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_rem_in   = rsp_rem_ff;

      meta_re    = 1'b0;
      meta_raddr = (req_bus.op == OP_DEQUEUE) ? sel_cls : CLW'(req_bus.class_id);
      meta_we    = 1'b0;
      meta_wdata = '0;
      store_we   = 1'b0;
      store_re   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               meta_re      = 1'b1;
               meta_hit_in  = meta_valid_ff[meta_raddr];
               cls_in       = meta_raddr;
               enq_class_in = req_bus.class_id;
               cls_ok_in    = (32'(req_bus.class_id) < 32'(NUM_CLASSES));
               deq_empty_in = !sel_any;
               idx_in       = req_bus.buffer_index;
            end
         end
         ST_ENQ: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_index_in = '0;
               rsp_class_in = enq_class_ff;
               rsp_rem_in   = '0;
               if (cls_ok_ff && !queue_full) begin
                  store_we              = 1'b1;
                  meta_we               = 1'b1;
                  meta_wdata            = {meta_head, meta_count + CW'(1)};
                  meta_valid_in[cls_ff] = 1'b1;
                  nonempty_in[cls_ff]   = 1'b1;
                  rsp_ok_in             = 1'b1;
                  rsp_pos_in            = POS_W'(meta_count);
               end else begin
                  rsp_ok_in  = 1'b0;
                  rsp_pos_in = '0;
               end
            end
         end
         ST_DEQ_META: begin
            if (!deq_empty_ff) begin
               store_re            = 1'b1;
               meta_we             = 1'b1;
               meta_wdata          = {head_next, count_dec};
               nonempty_in[cls_ff] = (count_dec != '0);
               last_served_in      = cls_ff;
               rem_in              = count_dec;
            end else if (out_free) begin
               rsp_load     = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_index_in = '0;
               rsp_class_in = '0;
               rsp_pos_in   = '0;
               rsp_rem_in   = '0;
            end
         end
         ST_DEQ_DATA: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_index_in = store_rdata;
               rsp_class_in = CLASS_W'(cls_ff);
               rsp_pos_in   = '0;
               rsp_rem_in   = POS_W'(rem_ff);
            end
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         meta_valid_ff  <= '0;
         nonempty_ff    <= '0;
         last_served_ff <= CLW'(NUM_CLASSES - 1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         meta_valid_ff  <= meta_valid_in;
         nonempty_ff    <= nonempty_in;
         last_served_ff <= last_served_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff       <= cls_in;
      enq_class_ff <= enq_class_in;
      cls_ok_ff    <= cls_ok_in;
      deq_empty_ff <= deq_empty_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      meta_hit_ff  <= meta_hit_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_index_ff <= rsp_index_in;
      rsp_class_ff <= rsp_class_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_rem_ff   <= rsp_rem_in;
   end

   // per-class head and count
   rrcqs_ram #(
      .WIDTH (MW),
      .DEPTH (NUM_CLASSES)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (cls_ff),
      .wdata (meta_wdata),
      .re    (meta_re),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   // packet index fifos, one region of QUEUE_DEPTH words per class
   rrcqs_ram #(
      .WIDTH (INDEX_W),
      .DEPTH (SD)
   ) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (idx_ff),
      .re    (store_re),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.ok             = rsp_ok_ff;
   assign rsp_bus.out_index      = rsp_index_ff;
   assign rsp_bus.out_class      = rsp_class_ff;
   assign rsp_bus.queue_position = rsp_pos_ff;
   assign rsp_bus.remaining      = rsp_rem_ff;

   `RRCQS_ASSERT(a_nonempty_has_meta, clock, reset, ($countones(nonempty_ff & ~meta_valid_ff) == 0), "non-empty class without head/count entry")
   `RRCQS_ASSERT(a_served_class_kept, clock, reset, ((state_ff == ST_DEQ_DATA) && ($past(state_ff) == ST_DEQ_META)) |-> (last_served_ff == cls_ff), "last served class not updated on pop")
   `RRCQS_ASSERT(a_empty_dequeue_flag, clock, reset, (req_fire && (req_bus.op == OP_DEQUEUE) && (nonempty_ff == '0)) |=> deq_empty_ff, "dequeue on empty bitmap not flagged")
   `RRCQS_ASSERT_ALWAYS(a_no_accept_busy, clock, (state_ff != ST_IDLE) |-> !req_bus.ready, "request taken while an item is in flight")

endmodule

// ----- tb/round_robin_class_queue_scheduler_tb.sv -----
// self-checking testbench of round_robin_class_queue_scheduler
// depends on rrcqs_pkg, the request/response channel interfaces and the top level rtl
module round_robin_class_queue_scheduler_tb;
   import rrcqs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] out_index;
      logic [CLASS_W-1:0] out_class;
      logic [POS_W-1:0]   queue_position;
      logic [POS_W-1:0]   remaining;
   } sched_rsp_type;

   typedef struct packed {
      op_type             op;
      logic [CLASS_W-1:0] class_id;
      logic [INDEX_W-1:0] buffer_index;
      logic               typed;
      sched_rsp_type      want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam int PHASE_BEATS   = 90;
   localparam int HOLD_CYCLES   = 250;
   localparam int DRAIN_CYCLES  = 10;

   // extremes, every class, wrap of the search and dequeues on empty queues
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 3'd0, 10'd0, 10'd0}},
      '{OP_ENQUEUE, 3'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 3'd0, 10'd0, 10'd0}},
      '{OP_ENQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 3'd7, 10'd0, 10'd0}},
      '{OP_ENQUEUE, 3'd7, 32'h1234_5678, 1'b1, '{1'b1, 32'h0000_0000, 3'd7, 10'd1, 10'd0}},
      '{OP_DEQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 3'd0, 10'd0, 10'd0}},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 3'd7, 10'd0, 10'd1}},
      '{OP_ENQUEUE, 3'd3, 32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0000_0000, 3'd3, 10'd0, 10'd0}},
      '{OP_DEQUEUE, 3'd5, 32'h5555_5555, 1'b1, '{1'b1, 32'hA5A5_A5A5, 3'd3, 10'd0, 10'd0}},
      '{OP_DEQUEUE, 3'd2, 32'hAAAA_AAAA, 1'b1, '{1'b1, 32'h1234_5678, 3'd7, 10'd0, 10'd0}},
      '{OP_DEQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 3'd0, 10'd0, 10'd0}},
      '{OP_ENQUEUE, 3'd1, 32'h5A5A_5A5A, 1'b0, '0},
      '{OP_ENQUEUE, 3'd2, 32'h0000_FFFF, 1'b0, '0},
      '{OP_ENQUEUE, 3'd4, 32'hFFFF_0000, 1'b0, '0},
      '{OP_ENQUEUE, 3'd5, 32'h8000_0000, 1'b0, '0},
      '{OP_ENQUEUE, 3'd6, 32'h0000_0001, 1'b0, '0},
      '{OP_ENQUEUE, 3'd6, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 3'd0, 10'd0, 10'd0}}
   };

   logic clock;
   logic reset;

   rrcqs_req_if req_bus ();
   rrcqs_rsp_if rsp_bus ();

   round_robin_class_queue_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scheduler state as seen by the checker
   logic [INDEX_W-1:0] class_fifo [NUM_CLASSES_DEF][$];
   int                 last_served = NUM_CLASSES_DEF - 1;

   sched_rsp_type pending_responses [$];
   int            mismatches = 0;
   int            sender_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_request = 0;

   always #6 clock = ~clock;

   function automatic int held_total();
      int sum;
      sum = 0;
      for (int c = 0; c < NUM_CLASSES_DEF; c++) sum += class_fifo[c].size();
      return sum;
   endfunction

   // applies one request to the local state and returns the response it earns
   function automatic sched_rsp_type schedule_outcome(op_type op, logic [CLASS_W-1:0] cls,
                                                      logic [INDEX_W-1:0] idx);
      sched_rsp_type r;
      int            c;
      r = '0;
      if (op == OP_ENQUEUE) begin
         r.out_class = cls;
         if (class_fifo[cls].size() < QUEUE_DEPTH_DEF) begin
            class_fifo[cls].push_back(idx);
            r.ok = 1'b1;
            r.queue_position = POS_W'(class_fifo[cls].size() - 1);
         end
      end else begin
         for (int step = 1; step <= NUM_CLASSES_DEF; step++) begin
            c = (last_served + step) % NUM_CLASSES_DEF;
            if (class_fifo[c].size() != 0) begin
               r.ok = 1'b1;
               r.out_index = class_fifo[c].pop_front();
               r.out_class = CLASS_W'(c);
               r.remaining = POS_W'(class_fifo[c].size());
               last_served = c;
               break;
            end
         end
      end
      return r;
   endfunction

   // offers one request beat; a typed response, if given, replaces the prediction
   task automatic send_beat(op_type op, logic [CLASS_W-1:0] cls, logic [INDEX_W-1:0] idx,
                            logic typed = 1'b0, sched_rsp_type want = '0);
      sched_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.class_id     <= cls;
      req_bus.buffer_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = schedule_outcome(op, cls, idx);
      pending_responses.push_back(typed ? want : predicted);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic random_traffic(int beats);
      int                 held;
      logic               deq;
      logic [CLASS_W-1:0] hot;
      hot = CLASS_W'($urandom_range(NUM_CLASSES_DEF - 1));
      for (int n = 0; n < beats; n++) begin
         held = held_total();
         if ($urandom_range(49) == 0) hot = CLASS_W'($urandom_range(NUM_CLASSES_DEF - 1));
         if (held == 0)
            deq = ($urandom_range(9) == 0);
         else if (held > 64)
            deq = ($urandom_range(99) < 70);
         else
            deq = ($urandom_range(99) < 45);
         if (deq)
            send_beat(OP_DEQUEUE, CLASS_W'($urandom_range(7)), $urandom);
         else if ($urandom_range(2) == 0)
            send_beat(OP_ENQUEUE, hot, $urandom);
         else
            send_beat(OP_ENQUEUE, CLASS_W'($urandom_range(7)), $urandom);
      end
   endtask

   function automatic void check_field(string name, logic [INDEX_W-1:0] want,
                                       logic [INDEX_W-1:0] got);
      if (want !== got) begin
         $display("time %0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // receiver: random stalls, plus a long hold-off when asked for one
   initial begin : rsp_receiver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      sched_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            $display("time %0t: response beat with none expected, actual ok=%b index=%h class=%0d",
                     $time, rsp_bus.ok, rsp_bus.out_index, rsp_bus.out_class);
            mismatches++;
         end else begin
            want = pending_responses.pop_front();
            check_field("ok", 32'(want.ok), 32'(rsp_bus.ok));
            check_field("out_index", want.out_index, rsp_bus.out_index);
            check_field("out_class", 32'(want.out_class), 32'(rsp_bus.out_class));
            check_field("queue_position", 32'(want.queue_position),
                        32'(rsp_bus.queue_position));
            check_field("remaining", 32'(want.remaining), 32'(rsp_bus.remaining));
         end
      end
   end

   initial begin : watchdog
      #10ms;
      $display("round_robin_class_queue_scheduler verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [CLASS_W-1:0] fill_class;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_ENQUEUE;
      req_bus.class_id = '0;
      req_bus.buffer_index = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_beat(DIRECTED[r].op, DIRECTED[r].class_id, DIRECTED[r].buffer_index,
                   DIRECTED[r].typed, DIRECTED[r].want);
      pause_until_drained();

      // fill one class to the brim and push past it; the random phases run on top
      sender_idle_pct = 28;
      recv_stall_pct = 28;
      fill_class = CLASS_W'($urandom_range(NUM_CLASSES_DEF - 1));
      for (int n = 0; n < QUEUE_DEPTH_DEF + 2; n++) send_beat(OP_ENQUEUE, fill_class, $urandom);
      for (int n = 0; n < 5; n++) send_beat(OP_ENQUEUE, fill_class + 3'd1, $urandom);
      pause_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct = 0;
               @(posedge clock);
               hold_request = HOLD_CYCLES;
            end
            1: begin
               sender_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               sender_idle_pct = 28;
               recv_stall_pct = 28;
            end
         endcase
         random_traffic(PHASE_BEATS);
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_responses.size() == 0)
         $display("round_robin_class_queue_scheduler verification clean");
      else
         $display("round_robin_class_queue_scheduler verification failed");
      $finish;
   end

endmodule
